>>> rtl/core/fixed_block_pool_allocator_top_assert.svh
// Assertion macros used by the checker file of the block pool allocator.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define FBPA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define FBPA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/fbpa_pkg.sv
// Shared types, codes and helpers of the fixed block pool allocator.
package fbpa_pkg;

	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int ADDR_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_REINIT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SIZE     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_BAD_FREE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		POOL_SEL_64   = 2'd0,
		POOL_SEL_256  = 2'd1,
		POOL_SEL_1K   = 2'd2
	} pool_sel_t;

	localparam logic [2:0] REG_POOL_SELECT = 3'd0;
	localparam logic [2:0] REG_POOL_BYTES  = 3'd1;
	localparam logic [2:0] REG_MIN_REQUEST = 3'd2;
	localparam logic [2:0] REG_MAX_REQUEST = 3'd3;
	localparam logic [2:0] REG_BASE_ADDR   = 3'd4;

	localparam logic [20:0] POOL_BYTES_RST  = 21'd65536;
	localparam logic [15:0] MIN_REQUEST_RST = 16'd1;
	localparam logic [15:0] MAX_REQUEST_RST = 16'd64;

	// Log2 of the block size for a pool select code.
	function automatic logic [3:0] block_shift(input logic [1:0] sel);
		logic [3:0] sh;
		case (sel)
			POOL_SEL_256: sh = 4'd8;
			POOL_SEL_1K:  sh = 4'd10;
			default:      sh = 4'd6;
		endcase
		return sh;
	endfunction

endpackage

>>> rtl/core/fbpa_link_mem.sv
// Link memory of the free list: one write port, one registered read port.
module fbpa_link_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [IW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator with a LIFO free list: top level.
//
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  tuser: command; tdata: request_size, free_address
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: block_address
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// One item per cycle while m_tready holds; each goes via input and result registers.
// The link memory read for a pop is issued in the same cycle as the pop, so the
// next link of the new head is ready for an alloc in the following cycle.
// Reset clears the configuration to its defaults and leaves a pool of no blocks
// until the first reinit; the link memory needs no clearing pass.
// A stalled result holds its register and the input register behind it.
module fixed_block_pool_allocator_top #(
	parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF,
	parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] request_size, [47:16] free_address
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] block_address
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	import fbpa_pkg::*;

	localparam int IW   = $clog2(NUM_BLOCKS);
	localparam int CW   = $clog2(NUM_BLOCKS + 1);
	localparam int AW   = ADDR_WIDTH;
	localparam int CMPW = (AW > CW) ? AW : CW;
	localparam logic [CW-1:0] NULL_IDX = CW'(NUM_BLOCKS);

	// Configuration registers.
	logic [1:0]  pool_select_q;
	logic [20:0] pool_bytes_q;
	logic [15:0] min_request_q;
	logic [15:0] max_request_q;
	logic [31:0] base_address_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_select_q  <= POOL_SEL_64;
			pool_bytes_q   <= POOL_BYTES_RST;
			min_request_q  <= MIN_REQUEST_RST;
			max_request_q  <= MAX_REQUEST_RST;
			base_address_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POOL_SELECT: pool_select_q  <= cfg_data[1:0];
				REG_POOL_BYTES:  pool_bytes_q   <= cfg_data[20:0];
				REG_MIN_REQUEST: min_request_q  <= cfg_data[15:0];
				REG_MAX_REQUEST: max_request_q  <= cfg_data[15:0];
				REG_BASE_ADDR:   base_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] size_s1;
	logic [31:0] faddr_s1;

	// Result register.
	logic        out_valid_q;
	status_t     out_status_q;
	logic [31:0] out_addr_q;

	logic fire_s1;

	assign fire_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			size_s1  <= s_tdata[15:0];
			faddr_s1 <= s_tdata[47:16];
		end
	end

	// Pool state.
	logic [CW-1:0] head_q;
	logic [CW-1:0] link_q;
	logic          link_from_mem_q;
	logic [CW-1:0] wm_q;
	logic [1:0]    geo_sel_q;
	logic [CW-1:0] geo_count_q;
	logic [AW-1:0] geo_base_q;

	logic [CW-1:0] rd_data;
	logic [CW-1:0] link_eff;

	// The cached next link of the head comes from the memory after a pop.
	assign link_eff = link_from_mem_q ? rd_data : link_q;

	logic          head_valid;
	logic [3:0]    shift;
	logic [CW-1:0] alloc_idx;
	logic [AW-1:0] alloc_addr;
	logic [AW-1:0] fa;
	logic [AW-1:0] off;
	logic [AW-1:0] low_mask;
	logic [AW-1:0] free_idx_w;
	logic [CW-1:0] free_idx;
	logic          free_ok;
	logic [3:0]    new_shift;
	logic [20:0]   new_count_raw;
	logic [CW-1:0] new_count;

	status_t       status;
	logic [31:0]   res_addr;
	logic          do_pop;
	logic          do_wm;
	logic          do_push;
	logic          do_reinit;

	assign head_valid = (head_q != NULL_IDX);
	assign shift      = block_shift(geo_sel_q);
	assign alloc_idx  = head_valid ? head_q : wm_q;
	assign alloc_addr = geo_base_q + (AW'(alloc_idx) << shift);

	assign fa         = AW'(faddr_s1);
	assign off        = fa - geo_base_q;
	assign low_mask   = ~({AW{1'b1}} << shift);
	assign free_idx_w = off >> shift;
	assign free_idx   = CW'(free_idx_w);
	// A block at or above the watermark was never handed out; that also bounds the index.
	assign free_ok    = (fa >= geo_base_q) && ((off & low_mask) == '0)
		&& (CMPW'(free_idx_w) < CMPW'(wm_q));

	assign new_shift     = block_shift(pool_select_q);
	assign new_count_raw = pool_bytes_q >> new_shift;
	assign new_count     = (32'(new_count_raw) > 32'(NUM_BLOCKS)) ? NULL_IDX
		: CW'(new_count_raw);

	always_comb begin
		status    = STAT_OK;
		res_addr  = '0;
		do_pop    = 1'b0;
		do_wm     = 1'b0;
		do_push   = 1'b0;
		do_reinit = 1'b0;
		unique case (cmd_s1)
			CMD_ALLOC: begin
				if (size_s1 < min_request_q || size_s1 > max_request_q) begin
					status = STAT_SIZE;
				end else if (head_valid) begin
					do_pop   = 1'b1;
					res_addr = 32'(alloc_addr);
				end else if (wm_q < geo_count_q) begin
					do_wm    = 1'b1;
					res_addr = 32'(alloc_addr);
				end else begin
					status = STAT_EMPTY;
				end
			end
			CMD_FREE: begin
				if (free_ok) begin
					do_push = 1'b1;
				end else begin
					status = STAT_BAD_FREE;
				end
			end
			CMD_REINIT: begin
				do_reinit = (pool_select_q <= POOL_SEL_1K);
			end
			default: ;
		endcase
	end

	logic          mem_wr_en;
	logic          mem_rd_en;

	assign mem_wr_en = fire_s1 && do_push;
	assign mem_rd_en = fire_s1 && do_pop && (link_eff != NULL_IDX);

	fbpa_link_mem #(
		.DEPTH (NUM_BLOCKS),
		.WIDTH (CW)
	) u_link (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (free_idx[IW-1:0]),
		.wr_data (head_q),
		.rd_en   (mem_rd_en),
		.rd_addr (link_eff[IW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q          <= NULL_IDX;
			link_q          <= NULL_IDX;
			link_from_mem_q <= 1'b0;
			wm_q            <= '0;
			geo_sel_q       <= POOL_SEL_64;
			geo_count_q     <= '0;
			geo_base_q      <= '0;
		end else if (fire_s1) begin
			if (do_pop) begin
				head_q          <= link_eff;
				link_from_mem_q <= 1'b1;
			end
			if (do_wm) begin
				wm_q <= wm_q + 1'b1;
			end
			if (do_push) begin
				head_q          <= free_idx;
				link_q          <= head_q;
				link_from_mem_q <= 1'b0;
			end
			if (do_reinit) begin
				head_q          <= NULL_IDX;
				link_q          <= NULL_IDX;
				link_from_mem_q <= 1'b0;
				wm_q            <= '0;
				geo_sel_q       <= pool_select_q;
				geo_count_q     <= new_count;
				geo_base_q      <= AW'(base_address_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_status_q <= status;
			out_addr_q   <= res_addr;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_addr_q;
	assign m_tuser  = out_status_q;

endmodule

>>> rtl/core/fbpa_checker.sv
// Port-level checker of the block pool allocator and its bind to the top level.
`include "fixed_block_pool_allocator_top_assert.svh"

module fbpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	import fbpa_pkg::*;

	logic [1:0] pending_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// Items accepted whose result transaction has not completed yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_fire && !out_fire) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_fire && !in_fire) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`FBPA_ASSERT_NOW(a_no_orphan_result, out_fire, pending_q != 2'd0, "result without a pending item")
	`FBPA_ASSERT_NOW(a_pending_bound, in_fire || out_fire || m_tvalid, pending_q != 2'd3, "more than two items in flight")
	`FBPA_ASSERT_NOW(a_addr_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == 32'd0, "failed result carries an address")
	`FBPA_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
